FILE: hdl/set_assoc_lru_cache_tag_model_unit_defines.svh
// Assertion macros for the set-associative LRU tag store.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef SET_ASSOC_LRU_CACHE_TAG_MODEL_UNIT_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_TAG_MODEL_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SALC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SALC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/salc_pkg.sv
// Shared constants, codes and types for the set-associative LRU tag store.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package salc_pkg;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;

    localparam int ADDR_W       = 64;
    localparam int AGE_W        = 32;
    localparam int CNT_W        = 32;
    localparam int CMD_W        = 2;
    localparam int OUTC_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 6;
    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 6;
    localparam int WAYS_CFG_W   = 4;
    localparam int SHAMT_W      = 7;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [OUTC_W-1:0]    t_outcome;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cmd CMD_LOAD    = 2'd0;
    localparam t_cmd CMD_STORE   = 2'd1;
    localparam t_cmd CMD_MODIFY  = 2'd2;
    localparam t_cmd CMD_INVALID = 2'd3;

    localparam t_outcome OUTC_HIT   = 2'd0;
    localparam t_outcome OUTC_MISS  = 2'd1;
    localparam t_outcome OUTC_EVICT = 2'd2;

    localparam t_cfg_idx CFG_SET_BITS   = 2'd0;
    localparam t_cfg_idx CFG_BLOCK_BITS = 2'd1;
    localparam t_cfg_idx CFG_WAYS       = 2'd2;

    localparam logic [SET_BITS_W-1:0]   RST_SET_BITS   = 3'd1;
    localparam logic [BLOCK_BITS_W-1:0] RST_BLOCK_BITS = 6'd4;
    localparam logic [WAYS_CFG_W-1:0]   RST_WAYS       = 4'd1;

    typedef struct packed {
        logic start;
        logic step;
    } t_scan_ctl;

    typedef struct packed {
        logic hit;
        logic has_free;
    } t_scan_flags;

endpackage

FILE: hdl/salc_tag_ram.sv
// Tag store memory: one row per set holding valid, tag and age of every way.
// Depends on salc_pkg; one write port and one read port with registered data.
`timescale 1ns / 1ps

module salc_tag_ram #(
    parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] i_wr_addr,
    input  logic [MAX_WAYS-1:0]                          i_wr_valid,
    input  logic [MAX_WAYS-1:0][salc_pkg::ADDR_W-1:0]    i_wr_tag,
    input  logic [MAX_WAYS-1:0][salc_pkg::AGE_W-1:0]     i_wr_age,
    input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] i_rd_addr,
    output logic [MAX_WAYS-1:0]                          o_rd_valid,
    output logic [MAX_WAYS-1:0][salc_pkg::ADDR_W-1:0]    o_rd_tag,
    output logic [MAX_WAYS-1:0][salc_pkg::AGE_W-1:0]     o_rd_age
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;

    logic [MAX_WAYS-1:0]                       r_mem_valid [NUM_SETS];
    logic [MAX_WAYS-1:0][salc_pkg::ADDR_W-1:0] r_mem_tag   [NUM_SETS];
    logic [MAX_WAYS-1:0][salc_pkg::AGE_W-1:0]  r_mem_age   [NUM_SETS];

    logic [MAX_WAYS-1:0]                       r_rd_valid;
    logic [MAX_WAYS-1:0][salc_pkg::ADDR_W-1:0] r_rd_tag;
    logic [MAX_WAYS-1:0][salc_pkg::AGE_W-1:0]  r_rd_age;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_valid[i_wr_addr] <= i_wr_valid;
            r_mem_tag[i_wr_addr]   <= i_wr_tag;
            r_mem_age[i_wr_addr]   <= i_wr_age;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_mem_valid[i_rd_addr];
        r_rd_tag   <= r_mem_tag[i_rd_addr];
        r_rd_age   <= r_mem_age[i_rd_addr];
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_tag   = r_rd_tag;
    assign o_rd_age   = r_rd_age;

endmodule

FILE: hdl/salc_way_scan.sv
// Shared way compare unit: examines one way per step and keeps the hit way,
// the highest free way and the oldest way seen so far. Depends on salc_pkg.
`timescale 1ns / 1ps

module salc_way_scan #(
    parameter int MAX_WAYS = salc_pkg::DEF_MAX_WAYS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  salc_pkg::t_scan_ctl                         i_ctl,
    input  logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] i_way,
    input  logic                                        i_valid,
    input  logic [salc_pkg::ADDR_W-1:0]                 i_tag,
    input  logic [salc_pkg::ADDR_W-1:0]                 i_key,
    input  logic [salc_pkg::AGE_W-1:0]                  i_age,
    output salc_pkg::t_scan_flags                       o_flags,
    output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] o_hit_way,
    output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] o_free_way,
    output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] o_victim
);

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic                          r_hit;
    logic                          r_has_free;
    logic [WAY_W-1:0]              r_hit_way;
    logic [WAY_W-1:0]              r_free_way;
    logic [WAY_W-1:0]              r_victim;
    logic [salc_pkg::AGE_W-1:0]    r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit      <= 1'b0;
            r_has_free <= 1'b0;
        end else if (i_ctl.start) begin
            r_hit      <= 1'b0;
            r_has_free <= 1'b0;
        end else if (i_ctl.step) begin
            if (i_valid && (i_tag == i_key)) begin
                r_hit <= 1'b1;
            end
            if (!i_valid) begin
                r_has_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_best   <= '0;
            r_victim <= '0;
        end else if (i_ctl.step) begin
            if (i_valid && (i_tag == i_key) && !r_hit) begin
                r_hit_way <= i_way;
            end
            if (!i_valid) begin
                r_free_way <= i_way;
            end
            if (i_age > r_best) begin
                r_best   <= i_age;
                r_victim <= i_way;
            end
        end
    end

    assign o_flags.hit      = r_hit;
    assign o_flags.has_free = r_has_free;
    assign o_hit_way        = r_hit_way;
    assign o_free_way       = r_free_way;
    assign o_victim         = r_victim;

endmodule

FILE: hdl/set_assoc_lru_cache_tag_model_unit.sv
// Usage: set-associative cache tag store with LRU replacement and running totals.
// Input channel (i_in_valid / o_in_ready) takes a command (load, store, modify)
// and a 64-bit byte address. Output channel (o_out_valid / i_out_ready) returns
// one item per access: outcome, last flag and the hit, miss and eviction totals.
// A load or store gives one item; a modify gives two, the second with last set.
// Command 3 is taken and gives nothing. Configuration registers (set bits,
// block bits, ways in use) are written through i_cfg_we and take effect at once.
// Each access passes through decode, set read, a scan of the ways in use in the
// shared compare unit (one way per step) and row update; the second access of a
// modify goes straight back to the scan.
// The store row is read once per item and updated in place for the second access.
// A finished item sits in the output register; the block accepts the next item
// meanwhile and only holds its row update while that register is full and i_out_ready is low.
// After reset the block clears the tag store, one set per cycle, through all
// 2^MAX_SET_BITS sets; input ready stays low during that pass.
// Depends on salc_pkg, salc_tag_ram, salc_way_scan and the defines header.
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_tag_model_unit_defines.svh"

module set_assoc_lru_cache_tag_model_unit #(
    parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [salc_pkg::CMD_W-1:0]         i_command,
    input  logic [salc_pkg::ADDR_W-1:0]        i_address,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [salc_pkg::OUTC_W-1:0]        o_outcome,
    output logic                               o_last,
    output logic [salc_pkg::CNT_W-1:0]         o_hit_total,
    output logic [salc_pkg::CNT_W-1:0]         o_miss_total,
    output logic [salc_pkg::CNT_W-1:0]         o_eviction_total
);

    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int ADDR_W = salc_pkg::ADDR_W;
    localparam int AGE_W  = salc_pkg::AGE_W;
    localparam int CNT_W  = salc_pkg::CNT_W;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_LOAD   = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_APPLY  = 3'd5;

    logic [2:0]                          r_state, n_state;
    logic [SET_W-1:0]                    r_clr;
    logic [salc_pkg::SET_BITS_W-1:0]     r_cfg_set_bits;
    logic [salc_pkg::BLOCK_BITS_W-1:0]   r_cfg_block_bits;
    logic [salc_pkg::WAYS_CFG_W-1:0]     r_cfg_ways;

    logic                                r_second;
    logic [ADDR_W-1:0]                   r_addr;
    logic [SET_W-1:0]                    r_set;
    logic [ADDR_W-1:0]                   r_tag;
    logic [WAY_W-1:0]                    r_way;

    logic [MAX_WAYS-1:0]                 r_row_valid;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]     r_row_tag;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      r_row_age;

    logic [CNT_W-1:0]                    r_hits, r_misses, r_evicts;
    logic                                r_out_valid;
    logic [salc_pkg::OUTC_W-1:0]         r_outcome;
    logic                                r_last;
    logic [CNT_W-1:0]                    r_out_hits, r_out_misses, r_out_evicts;

    logic [WCNT_W-1:0]                   eff_ways;
    logic [WAY_W-1:0]                    last_way;
    logic [salc_pkg::SET_BITS_W-1:0]     eff_sb;
    logic [salc_pkg::SHAMT_W-1:0]        tag_shamt;
    logic [ADDR_W-1:0]                   addr_shift;
    logic [ADDR_W-1:0]                   set_mask;
    logic [SET_W-1:0]                    dec_set;
    logic [ADDR_W-1:0]                   dec_tag;

    logic [MAX_WAYS-1:0]                 rd_valid;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]     rd_tag;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      rd_age;

    salc_pkg::t_scan_ctl                 scan_ctl;
    salc_pkg::t_scan_flags               scan_flags;
    logic [WAY_W-1:0]                    hit_way, free_way, victim, touch_way;

    logic [salc_pkg::OUTC_W-1:0]         apply_outcome;
    logic [MAX_WAYS-1:0]                 new_valid;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]     new_tag;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      new_age;
    logic                                out_free;
    logic                                commit;
    logic                                in_accept;

    logic                                wr_en;
    logic [SET_W-1:0]                    wr_addr;
    logic [SET_W-1:0]                    rd_addr;
    logic [MAX_WAYS-1:0]                 wr_valid;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]     wr_tag;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      wr_age;

    // Effective configuration.
    always_comb begin
        if (r_cfg_ways == '0) begin
            eff_ways = WCNT_W'(1);
        end else if (32'(r_cfg_ways) > MAX_WAYS) begin
            eff_ways = WCNT_W'(MAX_WAYS);
        end else begin
            eff_ways = WCNT_W'(r_cfg_ways);
        end
        last_way = WAY_W'(eff_ways - WCNT_W'(1));
        if (32'(r_cfg_set_bits) > MAX_SET_BITS) begin
            eff_sb = salc_pkg::SET_BITS_W'(MAX_SET_BITS);
        end else begin
            eff_sb = r_cfg_set_bits;
        end
    end

    // Address split into set index and tag.
    always_comb begin
        tag_shamt  = salc_pkg::SHAMT_W'(r_cfg_block_bits) + salc_pkg::SHAMT_W'(eff_sb);
        addr_shift = r_addr >> r_cfg_block_bits;
        set_mask   = (ADDR_W'(1) << eff_sb) - ADDR_W'(1);
        dec_set    = SET_W'(addr_shift & set_mask);
        if (tag_shamt >= salc_pkg::SHAMT_W'(ADDR_W)) begin
            dec_tag = '0;
        end else begin
            dec_tag = r_addr >> tag_shamt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign commit     = (r_state == S_APPLY) && out_free;

    always_comb begin
        scan_ctl.start = (r_state == S_LOAD) || (commit && r_second);
        scan_ctl.step  = (r_state == S_SCAN);
    end

    salc_way_scan #(
        .MAX_WAYS (MAX_WAYS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_way      (r_way),
        .i_valid    (r_row_valid[r_way]),
        .i_tag      (r_row_tag[r_way]),
        .i_key      (r_tag),
        .i_age      (r_row_age[r_way]),
        .o_flags    (scan_flags),
        .o_hit_way  (hit_way),
        .o_free_way (free_way),
        .o_victim   (victim)
    );

    // Row update for the access that the scan has just resolved.
    always_comb begin
        if (scan_flags.hit) begin
            apply_outcome = salc_pkg::OUTC_HIT;
            touch_way     = hit_way;
        end else if (scan_flags.has_free) begin
            apply_outcome = salc_pkg::OUTC_MISS;
            touch_way     = free_way;
        end else begin
            apply_outcome = salc_pkg::OUTC_EVICT;
            touch_way     = victim;
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            new_valid[w] = r_row_valid[w];
            new_tag[w]   = r_row_tag[w];
            new_age[w]   = r_row_age[w];
            if ((w < int'(eff_ways)) && r_row_valid[w]) begin
                new_age[w] = r_row_age[w] + AGE_W'(1);
            end
            if (WAY_W'(w) == touch_way) begin
                new_age[w] = '0;
                if (!scan_flags.hit) begin
                    new_valid[w] = 1'b1;
                    new_tag[w]   = r_tag;
                end
            end
        end
    end

    always_comb begin
        wr_en    = (r_state == S_CLEAR) || commit;
        wr_addr  = (r_state == S_CLEAR) ? r_clr : r_set;
        wr_valid = (r_state == S_CLEAR) ? '0 : new_valid;
        wr_tag   = (r_state == S_CLEAR) ? '0 : new_tag;
        wr_age   = (r_state == S_CLEAR) ? '0 : new_age;
        rd_addr  = dec_set;
    end

    salc_tag_ram #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_ram (
        .i_clk      (i_clk),
        .i_we       (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_valid (wr_valid),
        .i_wr_tag   (wr_tag),
        .i_wr_age   (wr_age),
        .i_rd_addr  (rd_addr),
        .o_rd_valid (rd_valid),
        .o_rd_tag   (rd_tag),
        .o_rd_age   (rd_age)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == SET_W'((1 << MAX_SET_BITS) - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept && (i_command != salc_pkg::CMD_INVALID)) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: n_state = S_LOAD;
            S_LOAD:   n_state = S_SCAN;
            S_SCAN: begin
                if (r_way == last_way) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (commit) begin
                    n_state = r_second ? S_SCAN : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_CLEAR;
            r_clr            <= '0;
            r_cfg_set_bits   <= salc_pkg::RST_SET_BITS;
            r_cfg_block_bits <= salc_pkg::RST_BLOCK_BITS;
            r_cfg_ways       <= salc_pkg::RST_WAYS;
            r_second         <= 1'b0;
            r_way            <= '0;
            r_hits           <= '0;
            r_misses         <= '0;
            r_evicts         <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + SET_W'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    salc_pkg::CFG_SET_BITS: begin
                        r_cfg_set_bits <= i_cfg_data[salc_pkg::SET_BITS_W-1:0];
                    end
                    salc_pkg::CFG_BLOCK_BITS: begin
                        r_cfg_block_bits <= i_cfg_data[salc_pkg::BLOCK_BITS_W-1:0];
                    end
                    salc_pkg::CFG_WAYS: begin
                        r_cfg_ways <= i_cfg_data[salc_pkg::WAYS_CFG_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (in_accept) begin
                r_second <= (i_command == salc_pkg::CMD_MODIFY);
            end
            if ((r_state == S_LOAD) || (commit && r_second)) begin
                r_way <= '0;
            end else if ((r_state == S_SCAN) && (r_way != last_way)) begin
                r_way <= r_way + WAY_W'(1);
            end
            if (commit) begin
                r_second <= 1'b0;
                if (apply_outcome == salc_pkg::OUTC_HIT) begin
                    r_hits <= r_hits + CNT_W'(1);
                end else begin
                    r_misses <= r_misses + CNT_W'(1);
                end
                if (apply_outcome == salc_pkg::OUTC_EVICT) begin
                    r_evicts <= r_evicts + CNT_W'(1);
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_addr <= i_address;
        end
        if (r_state == S_DECODE) begin
            r_set <= dec_set;
            r_tag <= dec_tag;
        end
        if (r_state == S_LOAD) begin
            r_row_valid <= rd_valid;
            r_row_tag   <= rd_tag;
            r_row_age   <= rd_age;
        end else if (commit) begin
            r_row_valid <= new_valid;
            r_row_tag   <= new_tag;
            r_row_age   <= new_age;
        end
        if (commit) begin
            r_outcome    <= apply_outcome;
            r_last       <= !r_second;
            r_out_hits   <= (apply_outcome == salc_pkg::OUTC_HIT) ?
                            r_hits + CNT_W'(1) : r_hits;
            r_out_misses <= (apply_outcome == salc_pkg::OUTC_HIT) ?
                            r_misses : r_misses + CNT_W'(1);
            r_out_evicts <= (apply_outcome == salc_pkg::OUTC_EVICT) ?
                            r_evicts + CNT_W'(1) : r_evicts;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_outcome        = r_outcome;
    assign o_last           = r_last;
    assign o_hit_total      = r_out_hits;
    assign o_miss_total     = r_out_misses;
    assign o_eviction_total = r_out_evicts;

    // Every committed access counts as exactly one hit or one miss.
    `SALC_ASSERT_NEXT(a_one_count, commit, (r_hits != $past(r_hits)) ^ (r_misses != $past(r_misses)), "access not counted once")
    // An eviction is always counted together with a miss.
    `SALC_ASSERT_NEXT(a_evict_is_miss, r_state == S_APPLY, (r_evicts == $past(r_evicts)) || (r_misses != $past(r_misses)), "eviction without miss")
    // The scan never steps past the last way in use.
    `SALC_ASSERT_NOW(a_scan_range, r_state == S_SCAN, r_way <= last_way, "scan beyond ways in use")

endmodule

FILE: tb/sv/set_assoc_lru_cache_tag_model_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the set-associative LRU tag store, with its own
// LRU predictor in a small scoreboard class and random handshake pressure.
// Depends on salc_pkg and set_assoc_lru_cache_tag_model_unit.

module set_assoc_lru_cache_tag_model_unit_tb;
    import salc_pkg::*;

    localparam int NUM_SETS     = 1 << DEF_MAX_SET_BITS;
    localparam int NUM_LINES    = NUM_SETS * DEF_MAX_WAYS;
    localparam int DRAIN_CYCLES = 2 * DEF_MAX_WAYS + 25;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 111;

    localparam t_cfg_idx CFG_SPARE = 2'd3;

    typedef enum int {RX_STEADY, RX_CHOPPY, RX_SPARSE} rx_mode_t;

    typedef struct packed {
        t_outcome           outcome;
        logic               last;
        logic [CNT_W-1:0]   hit_total;
        logic [CNT_W-1:0]   miss_total;
        logic [CNT_W-1:0]   eviction_total;
    } access_report_t;

    class tag_store_scoreboard;
        bit [SET_BITS_W-1:0]   set_bits_r   = RST_SET_BITS;
        bit [BLOCK_BITS_W-1:0] block_bits_r = RST_BLOCK_BITS;
        bit [WAYS_CFG_W-1:0]   ways_r       = RST_WAYS;
        bit                    line_valid [NUM_LINES];
        bit [ADDR_W-1:0]       line_tag   [NUM_LINES];
        bit [AGE_W-1:0]        line_age   [NUM_LINES];
        bit [CNT_W-1:0]        hits;
        bit [CNT_W-1:0]        misses;
        bit [CNT_W-1:0]        evictions;
        access_report_t        due_results[$];
        int                    errors;

        function int eff_set_bits();
            return (set_bits_r > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(set_bits_r);
        endfunction

        function int eff_ways();
            if (ways_r < 1) return 1;
            if (ways_r > DEF_MAX_WAYS) return DEF_MAX_WAYS;
            return int'(ways_r);
        endfunction

        function void apply_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SET_BITS:   set_bits_r = data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: block_bits_r = data[BLOCK_BITS_W-1:0];
                CFG_WAYS:       ways_r = data[WAYS_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function t_outcome lookup_access(int set_idx, bit [ADDR_W-1:0] tag);
            int  ways;
            int  base;
            int  free_way;
            int  victim;
            bit  full;
            bit [AGE_W-1:0] best;
            ways = eff_ways();
            base = set_idx * DEF_MAX_WAYS;
            free_way = 0;
            full = 1'b1;
            for (int w = 0; w < ways; w++) begin
                if (line_valid[base + w]) begin
                    if (line_tag[base + w] == tag) begin
                        hits++;
                        for (int j = 0; j < ways; j++)
                            if (line_valid[base + j]) line_age[base + j]++;
                        line_age[base + w] = '0;
                        return OUTC_HIT;
                    end
                end else begin
                    free_way = w;
                    full = 1'b0;
                end
            end
            misses++;
            if (!full) begin
                line_valid[base + free_way] = 1'b1;
                line_tag[base + free_way] = tag;
                for (int w = 0; w < ways; w++)
                    if (line_valid[base + w]) line_age[base + w]++;
                line_age[base + free_way] = '0;
                return OUTC_MISS;
            end
            evictions++;
            victim = 0;
            best = '0;
            for (int w = 0; w < ways; w++) begin
                if (line_age[base + w] > best) begin
                    best = line_age[base + w];
                    victim = w;
                end
            end
            line_tag[base + victim] = tag;
            for (int w = 0; w < ways; w++) line_age[base + w]++;
            line_age[base + victim] = '0;
            return OUTC_EVICT;
        endfunction

        function void note_item(t_cmd cmd, logic [ADDR_W-1:0] addr);
            int             esb;
            int             count;
            int             set_idx;
            bit [ADDR_W-1:0] tag;
            access_report_t rep;
            if (cmd == CMD_INVALID) return;
            count = (cmd == CMD_MODIFY) ? 2 : 1;
            esb = eff_set_bits();
            set_idx = int'((addr >> block_bits_r) & ((64'd1 << esb) - 64'd1));
            set_idx = set_idx & (NUM_SETS - 1);
            tag = (int'(block_bits_r) + esb >= ADDR_W) ? '0 : addr >> (int'(block_bits_r) + esb);
            for (int k = 0; k < count; k++) begin
                rep.outcome = lookup_access(set_idx, tag);
                rep.last = (k == count - 1);
                rep.hit_total = hits;
                rep.miss_total = misses;
                rep.eviction_total = evictions;
                due_results.push_back(rep);
            end
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(t_outcome outcome, logic last, logic [CNT_W-1:0] hit_total,
                          logic [CNT_W-1:0] miss_total, logic [CNT_W-1:0] eviction_total);
            access_report_t want;
            if (due_results.size() == 0) begin
                report_mismatch("result item with nothing outstanding");
                return;
            end
            want = due_results.pop_front();
            if (outcome !== want.outcome)
                report_mismatch($sformatf("outcome %0d, predicted %0d", outcome, want.outcome));
            if (last !== want.last)
                report_mismatch($sformatf("last %0b, predicted %0b", last, want.last));
            if (hit_total !== want.hit_total)
                report_mismatch($sformatf("hit_total %0d, predicted %0d",
                                          hit_total, want.hit_total));
            if (miss_total !== want.miss_total)
                report_mismatch($sformatf("miss_total %0d, predicted %0d",
                                          miss_total, want.miss_total));
            if (eviction_total !== want.eviction_total)
                report_mismatch($sformatf("eviction_total %0d, predicted %0d",
                                          eviction_total, want.eviction_total));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [CMD_W-1:0]      i_command = '0;
    logic [ADDR_W-1:0]     i_address = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [OUTC_W-1:0]     o_outcome;
    logic                  o_last;
    logic [CNT_W-1:0]      o_hit_total;
    logic [CNT_W-1:0]      o_miss_total;
    logic [CNT_W-1:0]      o_eviction_total;

    logic                  hold_off = 1'b0;
    int                    items_accepted = 0;
    int                    burst_left = 0;
    int                    tb_cycles = 0;
    tag_store_scoreboard   sb = new;

    set_assoc_lru_cache_tag_model_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_address        (i_address),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_outcome        (o_outcome),
        .o_last           (o_last),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_eviction_total (o_eviction_total)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            tb_cycles++;
            if (tb_cycles > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_item(t_cmd cmd, logic [ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_address <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(cmd, addr);
        items_accepted++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        sb.apply_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] set_data, logic [CFG_DATA_W-1:0] block_data,
                             logic [CFG_DATA_W-1:0] ways_data, bit poke_spare);
        write_reg(CFG_SET_BITS, set_data);
        write_reg(CFG_BLOCK_BITS, block_data);
        write_reg(CFG_WAYS, ways_data);
        if (poke_spare) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Most addresses reuse a few tags in a few sets so that hits and LRU evictions occur.
    task automatic run_random_phase(int n_items);
        logic [ADDR_W-1:0] tag_pool [12];
        logic [ADDR_W-1:0] addr;
        t_cmd              cmd;
        int                pool_size;
        int                esb;
        int                bb;
        int                sets_hi;
        int                made;
        pool_size = sb.eff_ways() + 3;
        esb = sb.eff_set_bits();
        bb = int'(sb.block_bits_r);
        foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(0, 19) == 0) cmd = CMD_INVALID;
            else cmd = t_cmd'($urandom_range(0, 2));
            if ($urandom_range(0, 6) == 0) begin
                addr = {$urandom, $urandom};
            end else begin
                sets_hi = (1 << esb) - 1;
                if ($urandom_range(0, 3) != 0 && sets_hi > 3) sets_hi = 3;
                addr = (tag_pool[$urandom_range(0, pool_size - 1)] << (bb + esb))
                     | (64'($urandom_range(0, sets_hi)) << bb)
                     | ({$urandom, $urandom} & ((64'd1 << bb) - 64'd1));
            end
            send_item(cmd, addr);
            if (cmd != CMD_INVALID) made++;
        end
    endtask

    initial begin
        rx_mode_t mode;
        int       stretch;
        bit       want;
        mode = RX_STEADY;
        stretch = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_result(o_outcome, o_last, o_hit_total, o_miss_total, o_eviction_total);
            if (stretch == 0) begin
                mode = rx_mode_t'($urandom_range(0, 2));
                stretch = $urandom_range(10, 150);
            end
            stretch--;
            case (mode)
                RX_STEADY: want = 1'b1;
                RX_CHOPPY: want = ($urandom_range(0, 1) == 1);
                default:   want = ($urandom_range(0, 3) == 0);
            endcase
            i_out_ready <= want && !hold_off;
        end
    end

    initial begin
        wait (items_accepted >= 150);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(CMD_LOAD, 64'h0);
        send_item(CMD_LOAD, 64'h0);
        send_item(CMD_STORE, 64'hF);
        send_item(CMD_MODIFY, 64'h10);
        send_item(CMD_LOAD, 64'h20);
        send_item(CMD_INVALID, 64'h20);
        send_item(CMD_LOAD, '1);
        send_item(CMD_STORE, '1);
        send_item(CMD_MODIFY, 64'h8000_0000_0000_0000);
        settle();
        configure(6'd2, 6'd4, 6'd3, 1'b1);
        send_item(CMD_LOAD, 64'h00);
        send_item(CMD_LOAD, 64'h40);
        send_item(CMD_STORE, 64'h80);
        send_item(CMD_LOAD, 64'h00);
        send_item(CMD_LOAD, 64'hC0);
        send_item(CMD_MODIFY, 64'h40);
        send_item(CMD_LOAD, 64'h0001_0000_0000_0030);
        settle();

        configure(6'd0, 6'd0, 6'd0, 1'b0);
        run_random_phase(PHASE_ITEMS);
        settle();
        configure(6'd7, 6'd63, 6'd15, 1'b0);
        run_random_phase(PHASE_ITEMS);
        settle();
        configure(6'd6, 6'd58, 6'd8, 1'b0);
        run_random_phase(PHASE_ITEMS);
        settle();
        configure(6'h3D, 6'd5, 6'h32, 1'b1);
        run_random_phase(PHASE_ITEMS);
        settle();
        configure(6'd1, 6'd60, 6'd9, 1'b0);
        run_random_phase(PHASE_ITEMS);
        settle();
        configure(6'd6, 6'd10, 6'd8, 1'b0);
        run_random_phase(PHASE_ITEMS);
        settle();
        configure(6'd2, 6'd4, 6'd4, 1'b0);
        run_random_phase(PHASE_ITEMS);
        settle();
        configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'b0);
        run_random_phase(PHASE_ITEMS);
        settle();

        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/salc_pkg.sv
hdl/salc_tag_ram.sv
hdl/salc_way_scan.sv
hdl/set_assoc_lru_cache_tag_model_unit.sv
tb/sv/set_assoc_lru_cache_tag_model_unit_tb.sv
